[sv/pspg_pkg.sv]
// Shared types and constants of the positional stereo pan gain block.
package pspg_pkg;

   localparam int SIN_W = 17;
   localparam int LSIN_W = 18;
   localparam int VOL_W = 16;
   localparam int PITCH_W = 16;
   localparam int GAIN_W = 16;
   localparam int NORM_W = 30;
   localparam int QUO_W = 18;
   localparam int DIST_W = 31;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [16:0] SIN_A = 17'd102944;
   localparam logic [15:0] SIN_B = 16'd42047;
   localparam logic [12:0] SIN_C = 13'd4640;
   localparam logic [PITCH_W-1:0] PITCH_MIN = 16'd41;
   localparam logic [PITCH_W-1:0] PITCH_ONE = 16'd4096;
   localparam logic [17:0] ONE_Q16 = 18'd65536;
   localparam logic [17:0] TWO_Q16 = 18'd131072;
   localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

   typedef enum logic [1:0] {
      REG_LISTENER_X,
      REG_LISTENER_Y,
      REG_LISTENER_Z,
      REG_LISTENER_HEADING
   } reg_idx_type;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

endpackage

[sv/pspg_sincos.sv]
// Pipelined polynomial sine of the listener right vector, with item sideband.
module pspg_sincos #(
   parameter int ANGLE_BITS = 16,
   parameter int SB_W = 104
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pspg_pkg::pipe_ctl_type    ctl_in,
   input  logic [ANGLE_BITS-1:0]     heading,
   input  logic [SB_W-1:0]           sb_in,
   output logic                      out_valid,
   output logic [SB_W-1:0]           sb_out,
   output logic signed [pspg_pkg::LSIN_W-1:0] lx_out,
   output logic signed [pspg_pkg::LSIN_W-1:0] lz_out
);
   import pspg_pkg::*;

   localparam int FW = ANGLE_BITS - 2;
   localparam int LAT = 5;
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << FW;
   localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (FW + 1);

   logic [LAT-1:0] valid_ff;
   logic [SB_W-1:0] sb_ff [LAT];
   logic [ANGLE_BITS-1:0] ang [2];

   logic [SIN_W-1:0] x1_ff [2], x2_ff [2], x3_ff [2], x4_ff [2];
   logic [SIN_W-1:0] x1_in [2];
   logic [3:0] neg_ff [2];
   logic neg_in [2];
   logic [SIN_W-1:0] sq2_ff [2], sq3_ff [2], sq2_in [2];
   logic [15:0] tb3_ff [2], tb3_in [2];
   logic [16:0] ta4_ff [2], ta4_in [2];
   logic signed [LSIN_W-1:0] s5_ff [2], s5_in [2];

   assign ang[0] = heading + QUARTER;
   assign ang[1] = heading + HALF;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [1:0] quad;
      logic [FW:0] fold;
      logic [FW+16:0] xw;
      logic [33:0] pxx;
      logic [29:0] pc;
      logic [32:0] pbt;
      logic [33:0] pxa;
      logic [16:0] sc;

      always_comb begin
         quad = ang[l][ANGLE_BITS-1 -: 2];
         fold = quad[0] ? ((FW+1)'(1) << FW) - {1'b0, ang[l][FW-1:0]}
                        : {1'b0, ang[l][FW-1:0]};
         xw = {fold, 16'b0} >> FW;
         x1_in[l] = xw[SIN_W-1:0];
         neg_in[l] = quad[1];

         pxx = 34'(x1_ff[l]) * 34'(x1_ff[l]) + 34'd32768;
         sq2_in[l] = pxx[32:16];

         pc = 30'(SIN_C) * 30'(sq2_ff[l]) + 30'd32768;
         tb3_in[l] = SIN_B - 16'(pc[29:16]);

         pbt = 33'(sq3_ff[l]) * 33'(tb3_ff[l]) + 33'd32768;
         ta4_in[l] = SIN_A - pbt[32:16];

         pxa = 34'(x4_ff[l]) * 34'(ta4_ff[l]) + 34'd32768;
         sc = (pxa[33:16] > 18'(ONE_Q16)) ? 17'(ONE_Q16) : pxa[32:16];
         if ((l == 0) != neg_ff[l][3]) begin
            s5_in[l] = -$signed({1'b0, sc});
         end else begin
            s5_in[l] = $signed({1'b0, sc});
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.en) begin
            x1_ff[l] <= x1_in[l];
            x2_ff[l] <= x1_ff[l];
            x3_ff[l] <= x2_ff[l];
            x4_ff[l] <= x3_ff[l];
            neg_ff[l] <= {neg_ff[l][2:0], neg_in[l]};
            sq2_ff[l] <= sq2_in[l];
            sq3_ff[l] <= sq2_ff[l];
            tb3_ff[l] <= tb3_in[l];
            ta4_ff[l] <= ta4_in[l];
            s5_ff[l] <= s5_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.en) begin
         valid_ff <= {valid_ff[LAT-2:0], ctl_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.en) begin
         sb_ff[0] <= sb_in;
         for (int k = 1; k < LAT; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign sb_out = sb_ff[LAT-1];
   assign lx_out = s5_ff[0];
   assign lz_out = s5_ff[1];

endmodule

[sv/pspg_isqrt.sv]
// Pipelined integer square root, one root bit per stage, over one or more lanes.
module pspg_isqrt #(
   parameter int IN_W = 62,
   parameter int LANES = 1,
   parameter int SB_W = 8,
   localparam int NS = (IN_W + 1) / 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pspg_pkg::pipe_ctl_type       ctl_in,
   input  logic [LANES-1:0][IN_W-1:0]   rad_data,
   input  logic [SB_W-1:0]              sb_in,
   output logic                         out_valid,
   output logic [LANES-1:0][NS-1:0]     root_data,
   output logic [SB_W-1:0]              sb_out
);
   import pspg_pkg::*;

   localparam int PW = 2 * NS;

   logic [LANES-1:0][PW-1:0] rad_ff [NS], rad_in [NS], rad_prev [NS];
   logic [LANES-1:0][NS+1:0] rem_ff [NS], rem_in [NS], rem_prev [NS];
   logic [LANES-1:0][NS-1:0] root_ff [NS], root_in [NS], root_prev [NS];
   logic [NS-1:0] valid_ff;
   logic [SB_W-1:0] sb_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_step
      if (k == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rad_prev[k][l] = PW'(rad_data[l]);
               rem_prev[k][l] = '0;
               root_prev[k][l] = '0;
            end
         end
      end else begin : g_next
         assign rad_prev[k] = rad_ff[k-1];
         assign rem_prev[k] = rem_ff[k-1];
         assign root_prev[k] = root_ff[k-1];
      end

      always_comb begin
         logic [NS+1:0] cat;
         logic [NS+1:0] trial;
         logic ge;
         for (int l = 0; l < LANES; l++) begin
            cat = {rem_prev[k][l][NS-1:0], rad_prev[k][l][PW-1 -: 2]};
            trial = {root_prev[k][l], 2'b01};
            ge = cat >= trial;
            rem_in[k][l] = ge ? cat - trial : cat;
            root_in[k][l] = {root_prev[k][l][NS-2:0], ge};
            rad_in[k][l] = rad_prev[k][l] << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (ctl_in.en) begin
            rad_ff[k] <= rad_in[k];
            rem_ff[k] <= rem_in[k];
            root_ff[k] <= root_in[k];
            sb_ff[k] <= (k == 0) ? sb_in : sb_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.en) begin
         valid_ff <= {valid_ff[NS-2:0], ctl_in.valid};
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign root_data = root_ff[NS-1];
   assign sb_out = sb_ff[NS-1];

endmodule

[sv/pspg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module pspg_div #(
   parameter int DW = 31,
   parameter int QW = 18,
   parameter int SB_W = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pspg_pkg::pipe_ctl_type  ctl_in,
   input  logic [DW+QW-1:0]        num,
   input  logic [DW-1:0]           den,
   input  logic [SB_W-1:0]         sb_in,
   output logic                    out_valid,
   output logic [QW-1:0]           quo,
   output logic [SB_W-1:0]         sb_out
);
   import pspg_pkg::*;

   logic [DW-1:0] rem_ff [QW], rem_in [QW], rem_prev [QW];
   logic [QW-1:0] num_ff [QW], num_in [QW], num_prev [QW];
   logic [DW-1:0] den_ff [QW], den_prev [QW];
   logic [QW-1:0] quo_ff [QW], quo_in [QW], quo_prev [QW];
   logic [QW-1:0] valid_ff;
   logic [SB_W-1:0] sb_ff [QW], sb_prev [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      if (k == 0) begin : g_first
         assign rem_prev[k] = num[DW+QW-1:QW];
         assign num_prev[k] = num[QW-1:0];
         assign den_prev[k] = den;
         assign quo_prev[k] = '0;
         assign sb_prev[k] = sb_in;
      end else begin : g_next
         assign rem_prev[k] = rem_ff[k-1];
         assign num_prev[k] = num_ff[k-1];
         assign den_prev[k] = den_ff[k-1];
         assign quo_prev[k] = quo_ff[k-1];
         assign sb_prev[k] = sb_ff[k-1];
      end

      always_comb begin
         logic [DW:0] t;
         logic ge;
         t = {rem_prev[k], num_prev[k][QW-1]};
         ge = t >= {1'b0, den_prev[k]};
         rem_in[k] = ge ? DW'(t - {1'b0, den_prev[k]}) : t[DW-1:0];
         quo_in[k] = {quo_prev[k][QW-2:0], ge};
         num_in[k] = num_prev[k] << 1;
      end

      always_ff @(posedge clock) begin
         if (ctl_in.en) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            den_ff[k] <= den_prev[k];
            quo_ff[k] <= quo_in[k];
            sb_ff[k] <= sb_prev[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.en) begin
         valid_ff <= {valid_ff[QW-2:0], ctl_in.valid};
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quo = quo_ff[QW-1];
   assign sb_out = sb_ff[QW-1];

endmodule

[sv/positional_stereo_pan_gain_core.sv]
// Top level of the positional stereo pan gain block.
//
// Each transfer on the req_ channel carries one sound event: position, volume and
// pitch. Each event gives exactly one transfer on the rsp_ channel with the left
// and right gains and the pitch, in the order the events came in.
// The listener position and heading are set through the csr_ port at byte
// addresses 0, 4, 8 and 12. The user must write them only while no event is in
// flight; the block itself does not enforce this. The datapath is one pipeline of
// 80 register stages: five for the heading sine, six for the differences,
// normalization and squares, 31 for the distance square root, 18 for the pan
// divider, 17 for the two gain square roots and a few more. An event can be
// accepted in every cycle while the pipeline is not held.
// When the receiver holds rsp_tready low with a response waiting, the whole
// pipeline holds and req_tready falls, so nothing is lost or repeated.
// Reset clears the listener registers and every stage valid bit.
module positional_stereo_pan_gain_core #(
   parameter int COORD_BITS = 24,
   parameter int ANGLE_BITS = 16,
   localparam int REQ_W = ((3 * COORD_BITS + 32 + 7) / 8) * 8,
   localparam int RSP_W = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // sound_x, sound_y, sound_z, volume, pitch
   input  logic [REQ_W-1:0]               req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // gain_left, gain_right, pitch_out
   output logic [RSP_W-1:0]               rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pspg_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pspg_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pspg_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                           csr_pready
);
   import pspg_pkg::*;

   localparam int CW = COORD_BITS;
   localparam int MW = CW + 1;
   localparam int PB = $clog2(MW + 1);
   localparam int SC_SB = 3 * CW + 32;
   localparam int SB6 = 50 + 2 + VOL_W + PITCH_W;
   localparam int SB7 = 3 + VOL_W + PITCH_W;
   localparam int SB8 = 1 + VOL_W + PITCH_W;
   localparam int RAD2_W = 33;
   localparam int ROOT2_W = (RAD2_W + 1) / 2;

   logic signed [CW-1:0] lis_x_ff, lis_y_ff, lis_z_ff;
   logic [ANGLE_BITS-1:0] head_ff;
   logic en;
   pipe_ctl_type ctl_sc, ctl_sq, ctl_dv, ctl_g;

   logic sc_valid;
   logic [SC_SB-1:0] sc_sb;
   logic signed [LSIN_W-1:0] sc_lx, sc_lz;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, rsp_valid_ff;

   logic signed [MW-1:0] d1x_ff, d1y_ff, d1z_ff;
   logic org1_ff, org2_ff, org3_ff, org4_ff, org5_ff, org6_ff;
   logic [VOL_W-1:0] vol1_ff, vol2_ff, vol3_ff, vol4_ff, vol5_ff, vol6_ff;
   logic [PITCH_W-1:0] pit1_ff, pit2_ff, pit3_ff, pit4_ff, pit5_ff, pit6_ff;
   logic signed [LSIN_W-1:0] lx1_ff, lz1_ff, lx2_ff, lz2_ff, lx3_ff, lz3_ff;
   logic signed [LSIN_W-1:0] lx4_ff, lz4_ff;

   logic [MW-1:0] u2x_ff, u2y_ff, u2z_ff, u2x_in, u2y_in, u2z_in, m2_ff, m2_in;
   logic [MW-1:0] u3x_ff, u3y_ff, u3z_ff;
   logic nx2_ff, nz2_ff, nx3_ff, nz3_ff, nx4_ff, nz4_ff;
   logic [PB-1:0] p3_ff, p3_in;
   logic zero3_ff, zero4_ff, zero5_ff, zero6_ff;

   logic [NORM_W-1:0] n4x_ff, n4y_ff, n4z_ff, n4x_in, n4y_in, n4z_in;
   logic [2*NORM_W-1:0] sq5x_ff, sq5y_ff, sq5z_ff;
   logic signed [NORM_W:0] snx, snz;
   logic signed [48:0] px5_ff, pz5_ff;
   logic [2*NORM_W+1:0] sum6_ff;
   logic signed [49:0] dot6_ff;

   logic sq_valid;
   logic [0:0][DIST_W-1:0] sq_root;
   logic [SB6-1:0] sq_sb;
   logic signed [49:0] sq_dot;

   logic [DIST_W+QUO_W-1:0] adot7_ff;
   logic [DIST_W-1:0] dist7_ff;
   logic [SB7-1:0] sb7_ff;

   logic dv_valid;
   logic [QUO_W-1:0] dv_quo;
   logic [SB7-1:0] dv_sb;
   logic [1:0][RAD2_W-1:0] rad8_ff;
   logic [SB8-1:0] sb8_ff;
   logic [16:0] qc;
   logic [17:0] pw;

   logic g_valid;
   logic [1:0][ROOT2_W-1:0] g_root;
   logic [SB8-1:0] g_sb;
   logic [GAIN_W-1:0] gl_in, gr_in, gl_ff, gr_ff;
   logic [PITCH_W-1:0] pout_ff;

   // Configuration port.
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lis_x_ff <= '0;
         lis_y_ff <= '0;
         lis_z_ff <= '0;
         head_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (reg_idx_type'(csr_paddr[3:2]))
            REG_LISTENER_X: lis_x_ff <= csr_pwdata[CW-1:0];
            REG_LISTENER_Y: lis_y_ff <= csr_pwdata[CW-1:0];
            REG_LISTENER_Z: lis_z_ff <= csr_pwdata[CW-1:0];
            REG_LISTENER_HEADING: head_ff <= csr_pwdata[ANGLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx_type'(csr_paddr[3:2]))
         REG_LISTENER_X: csr_prdata = CSR_DW'(lis_x_ff);
         REG_LISTENER_Y: csr_prdata = CSR_DW'(lis_y_ff);
         REG_LISTENER_Z: csr_prdata = CSR_DW'(lis_z_ff);
         REG_LISTENER_HEADING: csr_prdata = CSR_DW'(head_ff);
         default: csr_prdata = '0;
      endcase
   end

   // Pipeline advance.
   assign en = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign ctl_sc = '{en: en, valid: req_tvalid};
   assign ctl_sq = '{en: en, valid: v6_ff};
   assign ctl_dv = '{en: en, valid: v7_ff};
   assign ctl_g = '{en: en, valid: v8_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= sc_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= sq_valid;
         v8_ff <= dv_valid;
         rsp_valid_ff <= g_valid;
      end
   end

   pspg_sincos #(
      .ANGLE_BITS(ANGLE_BITS),
      .SB_W(SC_SB)
   ) u_sincos (
      .clock(clock),
      .reset(reset),
      .ctl_in(ctl_sc),
      .heading(head_ff),
      .sb_in(req_tdata[SC_SB-1:0]),
      .out_valid(sc_valid),
      .sb_out(sc_sb),
      .lx_out(sc_lx),
      .lz_out(sc_lz)
   );

   // Differences, magnitudes, normalization and products.
   always_comb begin
      u2x_in = d1x_ff[MW-1] ? MW'(-d1x_ff) : MW'(d1x_ff);
      u2y_in = d1y_ff[MW-1] ? MW'(-d1y_ff) : MW'(d1y_ff);
      u2z_in = d1z_ff[MW-1] ? MW'(-d1z_ff) : MW'(d1z_ff);
      m2_in = (u2x_in > u2y_in) ? u2x_in : u2y_in;
      if (u2z_in > m2_in) begin
         m2_in = u2z_in;
      end
   end

   always_comb begin
      p3_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (m2_ff[i]) begin
            p3_in = PB'(i);
         end
      end
   end

   always_comb begin
      logic [MW+NORM_W-1:0] ex, ey, ez;
      logic [PB:0] sh;
      sh = {1'b0, p3_ff} + (PB+1)'(1);
      ex = {u3x_ff, {NORM_W{1'b0}}} >> sh;
      ey = {u3y_ff, {NORM_W{1'b0}}} >> sh;
      ez = {u3z_ff, {NORM_W{1'b0}}} >> sh;
      n4x_in = ex[NORM_W-1:0];
      n4y_in = ey[NORM_W-1:0];
      n4z_in = ez[NORM_W-1:0];
   end

   assign snx = nx4_ff ? -$signed({1'b0, n4x_ff}) : $signed({1'b0, n4x_ff});
   assign snz = nz4_ff ? -$signed({1'b0, n4z_ff}) : $signed({1'b0, n4z_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         d1x_ff <= $signed(MW'($signed(sc_sb[CW-1:0]))) - MW'(lis_x_ff);
         d1y_ff <= $signed(MW'($signed(sc_sb[2*CW-1:CW]))) - MW'(lis_y_ff);
         d1z_ff <= $signed(MW'($signed(sc_sb[3*CW-1:2*CW]))) - MW'(lis_z_ff);
         org1_ff <= (sc_sb[3*CW-1:0] == '0);
         vol1_ff <= sc_sb[3*CW+VOL_W-1:3*CW];
         pit1_ff <= (sc_sb[SC_SB-1 -: PITCH_W] < PITCH_MIN) ? PITCH_ONE
                                                             : sc_sb[SC_SB-1 -: PITCH_W];
         lx1_ff <= sc_lx;
         lz1_ff <= sc_lz;

         u2x_ff <= u2x_in;
         u2y_ff <= u2y_in;
         u2z_ff <= u2z_in;
         m2_ff <= m2_in;
         nx2_ff <= d1x_ff[MW-1];
         nz2_ff <= d1z_ff[MW-1];
         org2_ff <= org1_ff;
         vol2_ff <= vol1_ff;
         pit2_ff <= pit1_ff;
         lx2_ff <= lx1_ff;
         lz2_ff <= lz1_ff;

         p3_ff <= p3_in;
         zero3_ff <= (m2_ff == '0);
         u3x_ff <= u2x_ff;
         u3y_ff <= u2y_ff;
         u3z_ff <= u2z_ff;
         nx3_ff <= nx2_ff;
         nz3_ff <= nz2_ff;
         org3_ff <= org2_ff;
         vol3_ff <= vol2_ff;
         pit3_ff <= pit2_ff;
         lx3_ff <= lx2_ff;
         lz3_ff <= lz2_ff;

         n4x_ff <= n4x_in;
         n4y_ff <= n4y_in;
         n4z_ff <= n4z_in;
         nx4_ff <= nx3_ff;
         nz4_ff <= nz3_ff;
         zero4_ff <= zero3_ff;
         org4_ff <= org3_ff;
         vol4_ff <= vol3_ff;
         pit4_ff <= pit3_ff;
         lx4_ff <= lx3_ff;
         lz4_ff <= lz3_ff;

         sq5x_ff <= (2*NORM_W)'(n4x_ff) * (2*NORM_W)'(n4x_ff);
         sq5y_ff <= (2*NORM_W)'(n4y_ff) * (2*NORM_W)'(n4y_ff);
         sq5z_ff <= (2*NORM_W)'(n4z_ff) * (2*NORM_W)'(n4z_ff);
         px5_ff <= 49'(snx) * 49'(lx4_ff);
         pz5_ff <= 49'(snz) * 49'(lz4_ff);
         zero5_ff <= zero4_ff;
         org5_ff <= org4_ff;
         vol5_ff <= vol4_ff;
         pit5_ff <= pit4_ff;

         sum6_ff <= (2*NORM_W+2)'(sq5x_ff) + (2*NORM_W+2)'(sq5y_ff)
                    + (2*NORM_W+2)'(sq5z_ff);
         dot6_ff <= 50'(px5_ff) + 50'(pz5_ff);
         zero6_ff <= zero5_ff;
         org6_ff <= org5_ff;
         vol6_ff <= vol5_ff;
         pit6_ff <= pit5_ff;
      end
   end

   pspg_isqrt #(
      .IN_W(2*NORM_W+2),
      .LANES(1),
      .SB_W(SB6)
   ) u_dist (
      .clock(clock),
      .reset(reset),
      .ctl_in(ctl_sq),
      .rad_data(sum6_ff),
      .sb_in({dot6_ff, zero6_ff, org6_ff, vol6_ff, pit6_ff}),
      .out_valid(sq_valid),
      .root_data(sq_root),
      .sb_out(sq_sb)
   );

   assign sq_dot = $signed(sq_sb[SB6-1 -: 50]);

   always_ff @(posedge clock) begin
      if (en) begin
         adot7_ff <= sq_dot[49] ? (DIST_W+QUO_W)'(-sq_dot) : (DIST_W+QUO_W)'(sq_dot);
         dist7_ff <= sq_root[0];
         sb7_ff <= {sq_dot[49], sq_sb[SB7-2:0]};
      end
   end

   pspg_div #(
      .DW(DIST_W),
      .QW(QUO_W),
      .SB_W(SB7)
   ) u_pan (
      .clock(clock),
      .reset(reset),
      .ctl_in(ctl_dv),
      .num(adot7_ff),
      .den(dist7_ff),
      .sb_in(sb7_ff),
      .out_valid(dv_valid),
      .quo(dv_quo),
      .sb_out(dv_sb)
   );

   // Pan position: the sign travels at the top of the sideband, zero distance next.
   always_comb begin
      qc = (dv_quo > QUO_W'(ONE_Q16)) ? 17'(ONE_Q16) : dv_quo[16:0];
      if (dv_sb[SB7-2]) begin
         pw = ONE_Q16;
      end else if (dv_sb[SB7-1]) begin
         pw = ONE_Q16 - 18'(qc);
      end else begin
         pw = ONE_Q16 + 18'(qc);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad8_ff[0] <= RAD2_W'(TWO_Q16 - pw) << 15;
         rad8_ff[1] <= RAD2_W'(pw) << 15;
         sb8_ff <= dv_sb[SB8-1:0];
      end
   end

   pspg_isqrt #(
      .IN_W(RAD2_W),
      .LANES(2),
      .SB_W(SB8)
   ) u_gain_root (
      .clock(clock),
      .reset(reset),
      .ctl_in(ctl_g),
      .rad_data(rad8_ff),
      .sb_in(sb8_ff),
      .out_valid(g_valid),
      .root_data(g_root),
      .sb_out(g_sb)
   );

   // Gains; the origin bypass flag sits at the top of the sideband.
   always_comb begin
      logic [VOL_W-1:0] vol;
      logic [33:0] pl, pr;
      vol = g_sb[VOL_W+PITCH_W-1:PITCH_W];
      pl = 34'(vol) * 34'(g_root[0]) + 34'd32768;
      pr = 34'(vol) * 34'(g_root[1]) + 34'd32768;
      gl_in = (pl[33:16] > 18'(GAIN_MAX)) ? GAIN_MAX : pl[31:16];
      gr_in = (pr[33:16] > 18'(GAIN_MAX)) ? GAIN_MAX : pr[31:16];
      if (g_sb[SB8-1]) begin
         gl_in = vol;
         gr_in = vol;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gl_ff <= gl_in;
         gr_ff <= gr_in;
         pout_ff <= g_sb[PITCH_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {pout_ff, gr_ff, gl_ff};

   a_norm_msb: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !zero4_ff) |-> (n4x_ff[NORM_W-1] || n4y_ff[NORM_W-1] || n4z_ff[NORM_W-1]))
      else $error("normalized magnitude lost its leading bit");

   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      (sq_valid && !sq_sb[SB6-51]) |-> (sq_root[0][DIST_W-1] || sq_root[0][DIST_W-2]))
      else $error("distance below normalized range");

   a_pitch_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_W-1 -: PITCH_W] >= PITCH_MIN))
      else $error("pitch below floor on response");

endmodule

[dv/pspg_checker.sv]
// Checker for the positional stereo pan gain block: predicts and compares each response.
`timescale 1ns / 100ps
module pspg_checker #(
   parameter int COORD_BITS = 24,
   parameter int ANGLE_BITS = 16,
   parameter int REQ_W = 104,
   parameter int RSP_W = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [REQ_W-1:0]            req_tdata,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [RSP_W-1:0]            rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pspg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pspg_pkg::CSR_DW-1:0] csr_pwdata,
   input  logic                        csr_pready,
   output int                          fail_count,
   output int                          pending_count
);
   import pspg_pkg::*;

   localparam logic [31:0] ANG_MASK = (32'd1 << ANGLE_BITS) - 1;
   localparam logic [31:0] ANG_QTR = 32'd1 << (ANGLE_BITS - 2);

   longint lis_x, lis_y, lis_z;
   logic [31:0] lis_head;
   logic [RSP_W-1:0] gains_due[$];

   function automatic longint sext(logic [63:0] v);
      logic [63:0] m;
      m = (64'd1 << COORD_BITS) - 1;
      v = v & m;
      if (v[COORD_BITS-1]) return longint'(v) - longint'(m) - 1;
      return longint'(v);
   endfunction

   function automatic longint sine_q16(logic [31:0] a);
      logic [31:0] quad, f;
      logic [63:0] x, x2, t, s;
      a = a & ANG_MASK;
      quad = (a >> (ANGLE_BITS - 2)) & 3;
      f = a & (ANG_QTR - 1);
      if (quad[0]) f = ANG_QTR - f;
      x = (64'(f) << 16) >> (ANGLE_BITS - 2);
      x2 = (x * x + 32768) >> 16;
      t = (64'(SIN_C) * x2 + 32768) >> 16;
      t = 64'(SIN_B) - t;
      t = (x2 * t + 32768) >> 16;
      t = 64'(SIN_A) - t;
      s = (x * t + 32768) >> 16;
      if (s > 65536) s = 65536;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_gain(logic [15:0] vol, logic [63:0] s);
      logic [63:0] g;
      g = (64'(vol) * s + 32768) >> 16;
      return g > 65535 ? GAIN_MAX : g[15:0];
   endfunction

   function automatic logic [RSP_W-1:0] pan_gains(logic [REQ_W-1:0] d);
      longint sx, sy, sz, dx, dy, dz, pan, nx, nz, lx, lz, dot;
      logic [63:0] ux, uy, uz, m, sum, span, q, pw;
      logic [15:0] vol, pitch, gl, gr;
      logic [31:0] h;
      sx = sext(64'(d[COORD_BITS-1:0]));
      sy = sext(64'(d[2*COORD_BITS-1:COORD_BITS]));
      sz = sext(64'(d[3*COORD_BITS-1:2*COORD_BITS]));
      vol = d[3*COORD_BITS +: 16];
      pitch = d[3*COORD_BITS+16 +: 16];
      gl = vol;
      gr = vol;
      if (pitch < PITCH_MIN) pitch = PITCH_ONE;
      if (sx != 0 || sy != 0 || sz != 0) begin
         dx = sx - lis_x;
         dy = sy - lis_y;
         dz = sz - lis_z;
         ux = dx < 0 ? -dx : dx;
         uy = dy < 0 ? -dy : dy;
         uz = dz < 0 ? -dz : dz;
         m = ux;
         pan = 0;
         if (uy > m) m = uy;
         if (uz > m) m = uz;
         if (m != 0) begin
            h = (lis_head + ANG_QTR) & ANG_MASK;
            while (m >= (64'd1 << 30)) begin
               m = m >> 1; ux = ux >> 1; uy = uy >> 1; uz = uz >> 1;
            end
            while (m < (64'd1 << 29)) begin
               m = m << 1; ux = ux << 1; uy = uy << 1; uz = uz << 1;
            end
            sum = ux * ux + uy * uy + uz * uz;
            span = int_sqrt(sum);
            nx = dx < 0 ? -longint'(ux) : longint'(ux);
            nz = dz < 0 ? -longint'(uz) : longint'(uz);
            lx = -sine_q16(h);
            lz = sine_q16(h + ANG_QTR);
            dot = nx * lx + nz * lz;
            q = (dot < 0 ? -dot : dot);
            q = q / span;
            if (q > 65536) q = 65536;
            pan = dot < 0 ? -longint'(q) : longint'(q);
         end
         pw = 64'(pan + 65536);
         gl = scale_gain(vol, int_sqrt((64'd131072 - pw) << 15));
         gr = scale_gain(vol, int_sqrt(pw << 15));
      end
      return {pitch, gr, gl};
   endfunction

   assign pending_count = gains_due.size();

   always @(posedge clock) begin
      logic [RSP_W-1:0] want;
      if (reset) begin
         lis_x <= 0;
         lis_y <= 0;
         lis_z <= 0;
         lis_head <= 0;
         fail_count <= 0;
         gains_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[3:2]))
               REG_LISTENER_X: lis_x <= sext(64'(csr_pwdata));
               REG_LISTENER_Y: lis_y <= sext(64'(csr_pwdata));
               REG_LISTENER_Z: lis_z <= sext(64'(csr_pwdata));
               REG_LISTENER_HEADING: lis_head <= csr_pwdata & ANG_MASK;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) gains_due.push_back(pan_gains(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (gains_due.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count <= fail_count + 1;
            end else begin
               want = gains_due.pop_front();
               if (rsp_tdata[15:0] !== want[15:0] || rsp_tdata[31:16] !== want[31:16]
                   || rsp_tdata[47:32] !== want[47:32]) begin
                  $display("%0t: exp gl %0d gr %0d po %0d, act gl %0d gr %0d po %0d",
                           $time, want[15:0], want[31:16], want[47:32],
                           rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32]);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[dv/tb_positional_stereo_pan_gain_core.sv]
// Testbench top: stimulus, register phases and verdict for the pan gain block.
`timescale 1ns / 100ps
module tb_positional_stereo_pan_gain_core;
   import pspg_pkg::*;

   localparam int REQ_W = 104;
   localparam int RSP_W = 48;
   localparam int LATENCY = 80;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;
   int fail_count, pending_count;
   int cycle_count = 0;
   int sent_count = 0;
   bit quiet_tail = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   positional_stereo_pan_gain_core u_dut (.*);

   pspg_checker #(.REQ_W(REQ_W), .RSP_W(RSP_W)) u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // The receiver stalls in random bursts until the final stretch.
   always begin
      int n;
      @(posedge clock);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 11);
         rsp_tready <= 0;
         repeat (n) @(posedge clock);
      end
      rsp_tready <= 1;
   end

   task automatic write_reg(reg_idx_type idx, logic [31:0] val);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   function automatic logic [23:0] pick_coord(int mode);
      case (mode)
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(0, 2047)) - 24'd1024;
         3: return 24'd0;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_event(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             logic [15:0] vol, logic [15:0] pit);
      int n;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 11);
         req_tvalid <= 0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {pit, vol, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic random_events(int count);
      logic [15:0] vol, pit;
      repeat (count) begin
         vol = $urandom_range(0, 7) == 0 ? 16'hFFFF : 16'($urandom);
         pit = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 60)) : 16'($urandom);
         if ($urandom_range(0, 19) == 0)
            send_event(0, 0, 0, vol, pit);
         else
            send_event(pick_coord($urandom_range(0, 6)), pick_coord($urandom_range(0, 6)),
                       pick_coord($urandom_range(0, 6)), vol, pit);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed events with the listener at the origin.
      send_event(0, 0, 0, 16'hFFFF, 16'd0);
      send_event(0, 0, 0, 16'd16384, 16'd40);
      send_event(24'd256, 0, 0, 16'd16384, 16'd41);
      send_event(-24'sd256, 0, 0, 16'hFFFF, 16'hFFFF);
      send_event(0, 0, 24'd256, 16'd16384, 16'd4096);
      send_event(0, 0, -24'sd256, 16'd16384, 16'd1);
      send_event(0, 24'd256, 0, 16'hFFFF, 16'd100);
      send_event(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 16'hFFFF);
      send_event(24'h800000, 24'h800000, 24'h800000, 16'd0, 16'd0);
      send_event(24'h7FFFFF, 24'h800000, 0, 16'hAAAA, 16'h5555);
      send_event(24'd1, 0, 0, 16'h5555, 16'hAAAA);
      drain();
      // A sound on the listener is centred.
      write_reg(REG_LISTENER_X, 32'd512);
      write_reg(REG_LISTENER_Y, 32'hFFFFFF00);
      write_reg(REG_LISTENER_Z, 32'd512);
      write_reg(REG_LISTENER_HEADING, 32'd16384);
      send_event(24'd512, 24'hFFFF00, 24'd512, 16'hFFFF, 16'd5000);
      send_event(0, 0, 0, 16'd1234, 16'd5000);
      send_event(24'd1024, 0, 24'd512, 16'd16384, 16'd5000);
      send_event(24'd512, 0, 24'd1024, 16'd16384, 16'd5000);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_reg(REG_LISTENER_X, 32'h007FFFFF);
               write_reg(REG_LISTENER_Z, 32'h00800000);
               write_reg(REG_LISTENER_HEADING, 32'hFFFF);
            end
            1: begin
               write_reg(REG_LISTENER_X, 32'h00800000);
               write_reg(REG_LISTENER_Y, 32'h007FFFFF);
               write_reg(REG_LISTENER_HEADING, 32'd32768);
            end
            5: begin
               write_reg(REG_LISTENER_X, 0);
               write_reg(REG_LISTENER_Y, 0);
               write_reg(REG_LISTENER_Z, 0);
               write_reg(REG_LISTENER_HEADING, 0);
            end
            default: begin
               write_reg(REG_LISTENER_X, 32'($urandom_range(0, 4095)) - 32'd2048);
               write_reg(REG_LISTENER_Y, $urandom);
               write_reg(REG_LISTENER_Z, 32'($urandom_range(0, 4095)) - 32'd2048);
               write_reg(REG_LISTENER_HEADING, $urandom);
            end
         endcase
         if (ph == 5) quiet_tail = 1;
         random_events(72);
         drain();
      end
      $display("Sent %0d sound events over eight listener settings,", sent_count);
      $display("including origin, centred, extreme and small pitch cases.");
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule

[sim.f]
sv/pspg_pkg.sv
sv/pspg_sincos.sv
sv/pspg_isqrt.sv
sv/pspg_div.sv
sv/positional_stereo_pan_gain_core.sv
dv/pspg_checker.sv
dv/tb_positional_stereo_pan_gain_core.sv
